// File: sv/ntpt_pkg.sv
// Package with the constants and lookup tables of the PWM tone settings block.
package ntpt_pkg;

  // System clock that the PWM timer runs from.
  localparam int unsigned CLOCK_HZ = 8000000;

  localparam logic [15:0] BEEP_WORD  = 16'd1;
  localparam logic [15:0] BEEP_TOP   = 16'd2048;
  localparam logic [10:0] DUTY_CLAMP = 11'd1920;
  localparam logic [3:0]  VOL_MAX    = 4'd10;
  localparam logic [3:0]  MIN_OCTAVE = 4'd3;
  localparam logic [3:0]  MAX_NOTE   = 4'd11;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_VOLUME_LEVEL    = 1'b0,
    REG_VOLUME_FRACTION = 1'b1
  } reg_idx_e;

  // Duty factor per volume step, in 1/256 of full scale.
  localparam logic [7:0] DUTY_TABLE [11] = '{
    8'd2, 8'd7, 8'd11, 8'd15, 8'd21, 8'd28, 8'd38, 8'd51, 8'd69, 8'd93, 8'd128
  };

  // Counter top for each note of the third octave, clock over frequency in
  // centihertz. Note indexes above eleven are flagged invalid and read zero.
  localparam logic [15:0] THIRD_TOP [16] = '{
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd13081),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd13859),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd14683),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd15556),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd16481),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd17461),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd18500),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd19600),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd20765),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd22000),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd23308),
    16'((64'(CLOCK_HZ) * 64'd100) / 64'd24694),
    16'd0, 16'd0, 16'd0, 16'd0
  };

endpackage

// File: sv/note_to_pwm_tone_settings.sv
// Top level: pipelined conversion of sound words into PWM timer settings.
// Each accepted item gives one result; a new item can be taken every cycle
// unless the output stalls. Stage one decodes the word, looks up the note's
// counter top and builds the duty factor, stage two clamps the top and
// multiplies by the duty factor, stage three applies the sleep scaling and
// forms the second compare value. Each stage holds its item while the next
// is full and stalled; with the output stalled, input is taken until all fill.
module note_to_pwm_tone_settings (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sound_word_i,
  input  logic        sleeping_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        enable_o,
  output logic [15:0] period_top_o,
  output logic [15:0] compare_a_o,
  output logic [15:0] compare_b_o,
  output logic        invalid_note_o
);

  logic [3:0] volume_level_q;
  logic [7:0] volume_fraction_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_level_q    <= 4'd5;
      volume_fraction_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (ntpt_pkg::reg_idx_e'(cfg_idx_i))
        ntpt_pkg::REG_VOLUME_LEVEL:    volume_level_q    <= cfg_wdata_i[3:0];
        ntpt_pkg::REG_VOLUME_FRACTION: volume_fraction_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake chain.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage one: decode, note lookup, duty factor.
  logic [3:0]  octave, note, oct_shift, vol_sat, vol, vol_nx;
  logic        is_beep, is_pause, is_bad;
  logic [15:0] note_top, top_d, duty_d;
  logic [7:0]  cm_lo, cm_hi, slope;

  assign octave    = sound_word_i[15:12];
  assign note      = sound_word_i[11:8];
  assign oct_shift = octave - ntpt_pkg::MIN_OCTAVE;
  assign is_beep   = sound_word_i == ntpt_pkg::BEEP_WORD;
  assign is_pause  = !is_beep && (sound_word_i[15:8] == 8'd0);
  assign is_bad    = !is_beep && !is_pause &&
                     ((octave < ntpt_pkg::MIN_OCTAVE) || (note > ntpt_pkg::MAX_NOTE));
  assign note_top  = ntpt_pkg::THIRD_TOP[note];

  // Pause and invalid words carry a zero top, which zeroes every later value.
  always_comb begin
    if (is_beep) begin
      top_d = ntpt_pkg::BEEP_TOP;
    end else if (is_pause || is_bad) begin
      top_d = 16'd0;
    end else begin
      top_d = note_top >> oct_shift;
    end
  end

  // At the top step the slope is zero, so no separate no-interpolation case.
  assign vol_sat = (volume_level_q > ntpt_pkg::VOL_MAX) ? ntpt_pkg::VOL_MAX
                                                        : volume_level_q;
  assign vol     = (sleeping_i && (vol_sat < ntpt_pkg::VOL_MAX)) ? vol_sat + 4'd1
                                                                 : vol_sat;
  assign vol_nx  = (vol < ntpt_pkg::VOL_MAX) ? vol + 4'd1 : vol;
  assign cm_lo   = ntpt_pkg::DUTY_TABLE[vol];
  assign cm_hi   = ntpt_pkg::DUTY_TABLE[vol_nx];
  assign slope   = cm_hi - cm_lo;
  assign duty_d  = {cm_lo, 8'd0} + (16'(slope) * 16'(volume_fraction_q));

  logic        en1_q, bad1_q, sleep1_q;
  logic [15:0] top1_q, duty1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      en1_q    <= !(is_pause || is_bad);
      bad1_q   <= is_bad;
      sleep1_q <= sleeping_i;
      top1_q   <= top_d;
      duty1_q  <= duty_d;
    end
  end

  // Stage two: clamp and multiply.
  logic [10:0] base;
  logic [26:0] prod;

  assign base = (top1_q > 16'(ntpt_pkg::DUTY_CLAMP)) ? ntpt_pkg::DUTY_CLAMP : top1_q[10:0];
  assign prod = 27'(base) * 27'(duty1_q);

  logic        en2_q, bad2_q, sleep2_q;
  logic [15:0] top2_q;
  logic [10:0] cmp2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      en2_q    <= en1_q;
      bad2_q   <= bad1_q;
      sleep2_q <= sleep1_q;
      top2_q   <= top1_q;
      cmp2_q   <= prod[26:16];
    end
  end

  // Stage three: sleep scaling for the slower clock and the second compare.
  logic [15:0] top3_d, cmp3_d;

  assign top3_d = sleep2_q ? (top2_q >> 2) : top2_q;
  assign cmp3_d = sleep2_q ? 16'(cmp2_q >> 2) : 16'(cmp2_q);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      enable_o       <= en2_q;
      invalid_note_o <= bad2_q;
      period_top_o   <= top3_d;
      compare_a_o    <= cmp3_d;
      compare_b_o    <= top3_d - cmp3_d;
    end
  end

  assign out_valid_o = v3_q;

endmodule

// File: sv/ntpt_checker.sv
// Port-level checker for the PWM tone settings block, bound to the top level.
module ntpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        enable_o,
  input logic [15:0] period_top_o,
  input logic [15:0] compare_a_o,
  input logic [15:0] compare_b_o,
  input logic        invalid_note_o
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(period_top_o) &&
    $stable(compare_a_o) && $stable(compare_b_o) && $stable(enable_o))
    else $error("result changed while stalled");

  // The two compare values are complementary within the period.
  a_complement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && enable_o |-> (compare_a_o <= period_top_o) &&
    (compare_b_o == period_top_o - compare_a_o))
    else $error("compare values do not sum to the period");

  // An invalid note never drives the buzzer.
  a_invalid_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_note_o |-> !enable_o)
    else $error("invalid note with buzzer enabled");

  // A result that turns the buzzer off carries all-zero settings.
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !enable_o |-> (period_top_o == 16'd0) && (compare_a_o == 16'd0) &&
    (compare_b_o == 16'd0))
    else $error("buzzer off with nonzero settings");

endmodule

bind note_to_pwm_tone_settings ntpt_checker u_ntpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .enable_o       (enable_o),
  .period_top_o   (period_top_o),
  .compare_a_o    (compare_a_o),
  .compare_b_o    (compare_b_o),
  .invalid_note_o (invalid_note_o)
);
